[rtl/core/bfra_pkg.sv]
`timescale 1ns / 1ps
package bfra_pkg;
    localparam int MAX_REGIONS_DEF = 64;
    localparam int ADDR_BITS_DEF   = 16;

    localparam int ID_W   = 16;
    localparam int SIZE_W = 17;
    localparam int TIME_W = 24;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 3'd0,
        REQ_REMOVE  = 3'd1,
        REQ_ADVANCE = 3'd2,
        REQ_COMPACT = 3'd3,
        REQ_QUERY   = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_DUP     = 3'd3,
        ST_FULL    = 3'd4
    } status_t;
endpackage

[rtl/core/best_fit_region_allocator.sv]
`timescale 1ns / 1ps
// Best-fit region allocator. Pulse start while busy is low to issue a request;
// one result appears on the result ports with done high for exactly one cycle
// and must be taken then, since the receiver cannot hold it off. The region
// table lives in one memory with a registered read and is walked one entry at a
// time, an address state then a data state. With N resident regions a request
// that leaves the table alone (query, failed insert or remove, compact with no
// free words, reserved codes) runs a search walk of N+1 steps, a decide state
// and a result state. Insert, remove, advance and compact add a rewrite walk of
// at most N+1 steps (insert shifts the entries above the new slot up one at a
// time, from the top). done rises in the cycle busy falls. A write on the cfg
// channel (accepted when idle and start is low) clears the table.
module best_fit_region_allocator #(
    parameter int MAX_REGIONS = bfra_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = bfra_pkg::ADDR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bfra_pkg::REQ_W-1:0]   req_type,
    input  logic [bfra_pkg::ID_W-1:0]    proc_id,
    input  logic [ADDR_BITS:0]           proc_size,
    input  logic [bfra_pkg::TIME_W-1:0]  time_left,
    input  logic [bfra_pkg::TIME_W-1:0]  time_delta,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ADDR_BITS:0]           cfg_data,
    output logic                         done,
    output logic [bfra_pkg::STAT_W-1:0]  status,
    output logic [ADDR_BITS-1:0]         address,
    output logic [ADDR_BITS:0]           free_space,
    output logic                         exists,
    output logic [ADDR_BITS:0]           min_hole,
    output logic [$clog2(MAX_REGIONS+1)-1:0] expired_count
);
    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int SW = ADDR_BITS + 1;
    localparam int TW = bfra_pkg::TIME_W;
    localparam int DW = bfra_pkg::ID_W + ADDR_BITS + SW + TW;
    localparam logic [SW-1:0] MAXW = SW'(1) << ADDR_BITS;

    typedef enum logic [2:0] {S_IDLE, S_SRD, S_SCAN, S_DEC, S_WRD, S_WALK, S_DONE} state_t;

    // table memory: {id, base, length, remaining}
    logic [DW-1:0] mem [MAX_REGIONS];
    logic [DW-1:0] rd_q;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    logic [bfra_pkg::ID_W-1:0] q_id;
    logic [ADDR_BITS-1:0]      q_base;
    logic [SW-1:0]             q_len;
    logic [TW-1:0]             q_rem;
    assign {q_id, q_base, q_len, q_rem} = rd_q;

    state_t state_reg;
    logic [SW-1:0] total_reg, free_reg;
    logic [CW-1:0] count_reg, idx_reg, widx_reg, exp_reg;
    logic [CW-1:0] fidx_reg, pos_reg;
    logic          found_id_reg, found_hole_reg;
    logic [SW-1:0] prev_end_reg, hole_size_reg, hole_base_reg, addr_acc_reg;
    logic [2:0]    req_reg;
    logic [bfra_pkg::ID_W-1:0] id_reg;
    logic [SW-1:0] size_reg;
    logic [TW-1:0] tleft_reg, delta_reg;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;

    // shared gap evaluator for the current search step
    logic [SW-1:0] next_b, gap;
    logic          gap_ok, in_tab;
    always_comb
    begin
        in_tab = idx_reg < count_reg;
        next_b = in_tab ? SW'(q_base) : total_reg;
        gap    = next_b - prev_end_reg;
        gap_ok = (next_b > prev_end_reg) && (gap >= size_reg)
                 && (!found_hole_reg || gap < hole_size_reg);
    end

    logic [SW-1:0] cfg_clamp;
    assign cfg_clamp = (cfg_data > MAXW) ? MAXW : cfg_data;

    // outcome of the search walk
    logic [bfra_pkg::STAT_W-1:0] dec_status;
    logic                        dec_walk;
    always_comb
    begin
        dec_status = bfra_pkg::ST_OK;
        dec_walk   = 1'b0;
        unique case (req_reg)
            bfra_pkg::REQ_INSERT:
                if (found_id_reg)
                    dec_status = bfra_pkg::ST_DUP;
                else if (count_reg >= CW'(MAX_REGIONS))
                    dec_status = bfra_pkg::ST_FULL;
                else if (size_reg == '0 || !found_hole_reg)
                    dec_status = bfra_pkg::ST_NOFIT;
                else
                    dec_walk = 1'b1;
            bfra_pkg::REQ_REMOVE:
                if (!found_id_reg)
                    dec_status = bfra_pkg::ST_UNKNOWN;
                else
                    dec_walk = 1'b1;
            bfra_pkg::REQ_ADVANCE:
                dec_walk = 1'b1;
            bfra_pkg::REQ_COMPACT:
                dec_walk = (free_reg != '0);
            default: ;
        endcase
    end

    always_comb
    begin
        // insert walks down from the top and reads the entry below the slot
        rd_addr = idx_reg[IW-1:0];
        if (state_reg == S_WRD && req_reg == bfra_pkg::REQ_INSERT)
            rd_addr = idx_reg[IW-1:0] - 1'b1;
        wr_en   = 1'b0;
        wr_addr = widx_reg[IW-1:0];
        wr_data = rd_q;
        if (state_reg == S_WALK)
        begin
            unique case (req_reg)
                bfra_pkg::REQ_INSERT:
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[IW-1:0];
                    if (idx_reg == pos_reg)
                        wr_data = {id_reg, hole_base_reg[ADDR_BITS-1:0], size_reg, tleft_reg};
                end
                bfra_pkg::REQ_REMOVE:
                    wr_en = (idx_reg < count_reg) && (idx_reg != fidx_reg);
                bfra_pkg::REQ_ADVANCE:
                begin
                    wr_en   = (idx_reg < count_reg) && (q_rem > delta_reg);
                    wr_data = {q_id, q_base, q_len, q_rem - delta_reg};
                end
                default:
                begin
                    wr_en   = (idx_reg < count_reg);
                    wr_addr = idx_reg[IW-1:0];
                    wr_data = {q_id, addr_acc_reg[ADDR_BITS-1:0], q_len, q_rem};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= MAXW;
            free_reg  <= MAXW;
            count_reg <= '0;
            done      <= 1'b0;
            idx_reg <= '0; widx_reg <= '0; exp_reg <= '0;
            fidx_reg <= '0; pos_reg <= '0;
            found_id_reg <= 1'b0; found_hole_reg <= 1'b0;
            prev_end_reg <= '0; hole_size_reg <= '0; hole_base_reg <= '0;
            addr_acc_reg <= '0;
            req_reg <= '0; id_reg <= '0; size_reg <= '0;
            tleft_reg <= '0; delta_reg <= '0;
            status <= '0; address <= '0; free_space <= '0;
            exists <= 1'b0; min_hole <= '0; expired_count <= '0;
        end
        else
        begin
            done <= (state_reg == S_DONE);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        total_reg <= cfg_clamp;
                        free_reg  <= cfg_clamp;
                        count_reg <= '0;
                    end
                    else if (start)
                    begin
                        req_reg <= req_type; id_reg <= proc_id; size_reg <= proc_size;
                        tleft_reg <= time_left; delta_reg <= time_delta;
                        idx_reg <= '0; widx_reg <= '0; exp_reg <= '0;
                        found_id_reg <= 1'b0; found_hole_reg <= 1'b0;
                        prev_end_reg <= '0; addr_acc_reg <= '0; hole_size_reg <= '0;
                        hole_base_reg <= '0; pos_reg <= '0;
                        state_reg <= S_SRD;
                    end
                end
                S_SRD:
                    state_reg <= S_SCAN;
                S_SCAN:
                begin
                    // one table entry (or the tail gap) per step; the slot for an
                    // insert is the entry just above the chosen hole
                    if (gap_ok)
                    begin
                        found_hole_reg <= 1'b1;
                        hole_size_reg  <= gap;
                        hole_base_reg  <= prev_end_reg;
                        pos_reg        <= idx_reg;
                    end
                    if (in_tab)
                    begin
                        if (q_id == id_reg && !found_id_reg)
                        begin
                            found_id_reg <= 1'b1;
                            fidx_reg     <= idx_reg;
                        end
                        prev_end_reg <= SW'(q_base) + q_len;
                        idx_reg      <= idx_reg + 1'b1;
                        state_reg    <= S_SRD;
                    end
                    else
                        state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    status        <= dec_status;
                    address       <= (dec_walk && req_reg == bfra_pkg::REQ_INSERT)
                                     ? hole_base_reg[ADDR_BITS-1:0] : '0;
                    exists        <= (req_reg == bfra_pkg::REQ_QUERY) && found_id_reg;
                    min_hole      <= (req_reg == bfra_pkg::REQ_QUERY && found_hole_reg)
                                     ? hole_size_reg : '0;
                    expired_count <= '0;
                    idx_reg       <= (req_reg == bfra_pkg::REQ_INSERT) ? count_reg : '0;
                    state_reg     <= dec_walk ? S_WRD : S_DONE;
                end
                S_WRD:
                    state_reg <= S_WALK;
                S_WALK:
                begin
                    unique case (req_reg)
                        bfra_pkg::REQ_INSERT:
                        begin
                            // shift the tail up one entry, then drop the new one in
                            if (idx_reg == pos_reg)
                            begin
                                free_reg  <= free_reg - size_reg;
                                count_reg <= count_reg + 1'b1;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg - 1'b1;
                                state_reg <= S_WRD;
                            end
                        end
                        bfra_pkg::REQ_REMOVE:
                        begin
                            if (idx_reg >= count_reg)
                            begin
                                free_reg  <= free_reg + addr_acc_reg;
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                // hold the removed length in the accumulator
                                if (idx_reg == fidx_reg)
                                    addr_acc_reg <= q_len;
                                else
                                    widx_reg <= widx_reg + 1'b1;
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_WRD;
                            end
                        end
                        bfra_pkg::REQ_ADVANCE:
                        begin
                            if (idx_reg >= count_reg)
                            begin
                                count_reg     <= widx_reg;
                                free_reg      <= free_reg + addr_acc_reg;
                                expired_count <= exp_reg;
                                state_reg     <= S_DONE;
                            end
                            else
                            begin
                                if (q_rem > delta_reg)
                                    widx_reg <= widx_reg + 1'b1;
                                else
                                begin
                                    exp_reg      <= exp_reg + 1'b1;
                                    addr_acc_reg <= addr_acc_reg + q_len;
                                end
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_WRD;
                            end
                        end
                        default:
                        begin
                            if (idx_reg >= count_reg)
                                state_reg <= S_DONE;
                            else
                            begin
                                addr_acc_reg <= addr_acc_reg + q_len;
                                idx_reg      <= idx_reg + 1'b1;
                                state_reg    <= S_WRD;
                            end
                        end
                    endcase
                end
                S_DONE:
                begin
                    free_space <= free_reg;
                    state_reg  <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result while busy");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_REGIONS))
        else $error("region count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) free_reg <= total_reg)
        else $error("free words exceed size");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request not taken");
endmodule

[tb/best_fit_region_allocator_tb.sv]
`timescale 1ns / 1ps
module best_fit_region_allocator_tb;

    localparam int NREG  = 64;
    localparam int ABITS = 16;
    localparam int WORDS = 1 << ABITS;

    localparam logic [bfra_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [bfra_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [bfra_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [bfra_pkg::STAT_W-1:0] st;
        logic [ABITS-1:0]  addr;
        logic [ABITS:0]    free_w;
        logic              ex;
        logic [ABITS:0]    hole;
        logic [6:0]        expired;
    } alloc_result_t;

    typedef struct {
        logic [bfra_pkg::REQ_W-1:0]  req;
        logic [bfra_pkg::ID_W-1:0]   id;
        logic [ABITS:0]              size;
        logic [bfra_pkg::TIME_W-1:0] tl;
        logic [bfra_pkg::TIME_W-1:0] dl;
        bit                          typed;
        alloc_result_t               res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [bfra_pkg::REQ_W-1:0] req_type = '0;
    logic [bfra_pkg::ID_W-1:0] proc_id = '0;
    logic [ABITS:0] proc_size = '0;
    logic [bfra_pkg::TIME_W-1:0] time_left = '0;
    logic [bfra_pkg::TIME_W-1:0] time_delta = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ABITS:0] cfg_data = '0;
    logic done;
    logic [bfra_pkg::STAT_W-1:0] status;
    logic [ABITS-1:0] address;
    logic [ABITS:0] free_space;
    logic exists;
    logic [ABITS:0] min_hole;
    logic [6:0] expired_count;

    best_fit_region_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .proc_id(proc_id), .proc_size(proc_size),
        .time_left(time_left), .time_delta(time_delta),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .status(status), .address(address), .free_space(free_space),
        .exists(exists), .min_hole(min_hole), .expired_count(expired_count)
    );

    always #10 clk = ~clk;

    // region table mirror, sorted by base
    logic [bfra_pkg::ID_W-1:0]   tbl_id  [NREG];
    int                          tbl_base[NREG];
    int                          tbl_len [NREG];
    logic [bfra_pkg::TIME_W-1:0] tbl_rem [NREG];
    int                tbl_cnt;
    int                mem_words;
    int                free_words;

    alloc_result_t pending_results[$];
    dir_row_t      dir_rows[$];
    int            errors = 0;
    bit            quiet = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit smallest_hole(input int need, output int hb, output int hs);
        int prev_end;
        int nxt;
        bit found;
        prev_end = 0;
        found = 1'b0;
        hb = 0;
        hs = 0;
        for (int i = 0; i <= tbl_cnt; i++)
        begin
            nxt = (i < tbl_cnt) ? tbl_base[i] : mem_words;
            if (nxt > prev_end && nxt - prev_end >= need && (!found || nxt - prev_end < hs))
            begin
                found = 1'b1;
                hs = nxt - prev_end;
                hb = prev_end;
            end
            if (i < tbl_cnt)
                prev_end = tbl_base[i] + tbl_len[i];
        end
        return found;
    endfunction

    function automatic int locate_id(input logic [bfra_pkg::ID_W-1:0] id);
        for (int i = 0; i < tbl_cnt; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void free_region(input int k);
        free_words += tbl_len[k];
        for (int i = k; i + 1 < tbl_cnt; i++)
        begin
            tbl_id[i]   = tbl_id[i + 1];
            tbl_base[i] = tbl_base[i + 1];
            tbl_len[i]  = tbl_len[i + 1];
            tbl_rem[i]  = tbl_rem[i + 1];
        end
        tbl_cnt--;
    endfunction

    function automatic void set_size(input logic [ABITS:0] v);
        mem_words  = (int'(v) > WORDS) ? WORDS : int'(v);
        tbl_cnt    = 0;
        free_words = mem_words;
    endfunction

    function automatic alloc_result_t predict_request(input logic [bfra_pkg::REQ_W-1:0] req,
                                                     input logic [bfra_pkg::ID_W-1:0] id,
                                                     input logic [ABITS:0] size,
                                                     input logic [bfra_pkg::TIME_W-1:0] tl,
                                                     input logic [bfra_pkg::TIME_W-1:0] dl);
        alloc_result_t r;
        int hb;
        int hs;
        int pos;
        int k;
        int a;
        r = '0;
        r.st = bfra_pkg::ST_OK;
        case (req)
            bfra_pkg::REQ_INSERT:
            begin
                if (locate_id(id) >= 0)
                    r.st = bfra_pkg::ST_DUP;
                else if (tbl_cnt >= NREG)
                    r.st = bfra_pkg::ST_FULL;
                else if (size == 0 || !smallest_hole(int'(size), hb, hs))
                    r.st = bfra_pkg::ST_NOFIT;
                else
                begin
                    pos = 0;
                    while (pos < tbl_cnt && tbl_base[pos] < hb)
                        pos++;
                    for (int i = tbl_cnt; i > pos; i--)
                    begin
                        tbl_id[i]   = tbl_id[i - 1];
                        tbl_base[i] = tbl_base[i - 1];
                        tbl_len[i]  = tbl_len[i - 1];
                        tbl_rem[i]  = tbl_rem[i - 1];
                    end
                    tbl_id[pos]   = id;
                    tbl_base[pos] = hb;
                    tbl_len[pos]  = int'(size);
                    tbl_rem[pos]  = tl;
                    tbl_cnt++;
                    free_words -= int'(size);
                    r.addr = hb[ABITS-1:0];
                end
            end
            bfra_pkg::REQ_REMOVE:
            begin
                k = locate_id(id);
                if (k < 0)
                    r.st = bfra_pkg::ST_UNKNOWN;
                else
                    free_region(k);
            end
            bfra_pkg::REQ_ADVANCE:
            begin
                k = 0;
                while (k < tbl_cnt)
                begin
                    if (tbl_rem[k] <= dl)
                    begin
                        free_region(k);
                        r.expired++;
                    end
                    else
                    begin
                        tbl_rem[k] -= dl;
                        k++;
                    end
                end
            end
            bfra_pkg::REQ_COMPACT:
            begin
                if (free_words != 0)
                begin
                    a = 0;
                    for (int i = 0; i < tbl_cnt; i++)
                    begin
                        tbl_base[i] = a;
                        a += tbl_len[i];
                    end
                end
            end
            bfra_pkg::REQ_QUERY:
            begin
                r.ex = (locate_id(id) >= 0);
                if (smallest_hole(int'(size), hb, hs))
                    r.hole = hs[ABITS:0];
            end
            default: ;
        endcase
        r.free_w = free_words[ABITS:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("ERROR @%0t: result with nothing pending", $realtime);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)          report_mismatch("status", status, e.st);
                if (address !== e.addr)       report_mismatch("address", address, e.addr);
                if (free_space !== e.free_w)  report_mismatch("free_space", free_space, e.free_w);
                if (exists !== e.ex)          report_mismatch("exists", exists, e.ex);
                if (min_hole !== e.hole)      report_mismatch("min_hole", min_hole, e.hole);
                if (expired_count !== e.expired)
                    report_mismatch("expired_count", expired_count, e.expired);
            end
        end
    end

    // one request transfer; a typed row overrides the predicted result
    task automatic issue(input dir_row_t row);
        alloc_result_t p;
        while (!quiet && $urandom_range(99) < 12)
            @(negedge clk);
        @(negedge clk);
        req_type   = row.req;
        proc_id    = row.id;
        proc_size  = row.size;
        time_left  = row.tl;
        time_delta = row.dl;
        start      = 1'b1;
        do @(posedge clk); while (busy);
        p = predict_request(row.req, row.id, row.size, row.tl, row.dl);
        pending_results.push_back(row.typed ? row.res : p);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(input logic [ABITS:0] v);
        @(negedge clk);
        cfg_data  = v;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        set_size(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(input logic [bfra_pkg::REQ_W-1:0] req,
                           input logic [bfra_pkg::ID_W-1:0] id, input logic [ABITS:0] size,
                           input logic [bfra_pkg::TIME_W-1:0] tl,
                           input logic [bfra_pkg::TIME_W-1:0] dl, input bit typed,
                           input logic [bfra_pkg::STAT_W-1:0] st,
                           input logic [ABITS-1:0] addr, input logic [ABITS:0] fw,
                           input bit ex, input logic [ABITS:0] hole,
                           input logic [6:0] expired);
        dir_row_t d;
        d.req = req; d.id = id; d.size = size; d.tl = tl; d.dl = dl; d.typed = typed;
        d.res.st = st; d.res.addr = addr; d.res.free_w = fw; d.res.ex = ex;
        d.res.hole = hole; d.res.expired = expired;
        dir_rows.push_back(d);
    endtask

    function automatic dir_row_t random_item();
        dir_row_t d;
        int w;
        d.typed = 1'b0;
        d.res = '0;
        w = $urandom_range(99);
        if (w < 42)      d.req = bfra_pkg::REQ_INSERT;
        else if (w < 62) d.req = bfra_pkg::REQ_REMOVE;
        else if (w < 74) d.req = bfra_pkg::REQ_ADVANCE;
        else if (w < 82) d.req = bfra_pkg::REQ_COMPACT;
        else if (w < 96) d.req = bfra_pkg::REQ_QUERY;
        else             d.req = 3'($urandom_range(5, 7));
        d.id = ($urandom_range(9) < 8) ? 16'($urandom_range(31)) : 16'($urandom);
        w = $urandom_range(19);
        if (w == 0)      d.size = 17'($urandom);
        else if (w == 1) d.size = '0;
        else             d.size = 17'($urandom_range(1, mem_words / 24 + 1));
        w = $urandom_range(19);
        if (w == 0)      d.tl = 24'($urandom);
        else if (w == 1) d.tl = '0;
        else             d.tl = 24'($urandom_range(1, 60));
        d.dl = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12));
        return d;
    endfunction

    initial
    begin
        int sizes[8];
        sizes = '{WORDS, 1, 0, 100000, 131071, 300, 4096, WORDS - 1};
        set_size(17'(WORDS));
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(bfra_pkg::REQ_QUERY,   5, 0, 0, 0, 1, bfra_pkg::ST_OK, 0, WORDS, 0, WORDS, 0);
        add_row(bfra_pkg::REQ_REMOVE,  7, 0, 0, 0, 1, bfra_pkg::ST_UNKNOWN, 0, WORDS, 0, 0, 0);
        add_row(bfra_pkg::REQ_INSERT,  1, WORDS, 1, 0, 1, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_INSERT,  2, 1, 1, 0, 1, bfra_pkg::ST_NOFIT, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_INSERT,  1, 1, 1, 0, 1, bfra_pkg::ST_DUP, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_COMPACT, 0, 0, 0, 0, 1, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_QUERY,   1, 1, 0, 0, 1, bfra_pkg::ST_OK, 0, 0, 1, 0, 0);
        add_row(bfra_pkg::REQ_ADVANCE, 0, 0, 0, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_ADVANCE, 0, 0, 0, 1, 1, bfra_pkg::ST_OK, 0, WORDS, 0, 0, 1);
        add_row(bfra_pkg::REQ_INSERT,  16'hFFFF, 0, 5, 0, 1, bfra_pkg::ST_NOFIT,
                0, WORDS, 0, 0, 0);
        add_row(bfra_pkg::REQ_INSERT,  3, 100, 0, 0, 1, bfra_pkg::ST_OK,
                0, WORDS - 100, 0, 0, 0);
        add_row(bfra_pkg::REQ_ADVANCE, 0, 0, 0, 0, 1, bfra_pkg::ST_OK, 0, WORDS, 0, 0, 1);
        add_row(bfra_pkg::REQ_INSERT,  10, 10, 24'hFFFFFF, 0, 0, bfra_pkg::ST_OK,
                0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_INSERT,  11, 20, 3, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_INSERT,  12, 30, 9, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_REMOVE,  11, 0, 0, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_INSERT,  13, 5, 2, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_QUERY,   12, 0, 0, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_QUERY,   11, 17'h1FFFF, 0, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_COMPACT, 0, 0, 0, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(REQ_RSVD5,   12, 7, 7, 7, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(REQ_RSVD6,   0, 0, 0, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(REQ_RSVD7,   0, 0, 0, 0, 0, bfra_pkg::ST_OK, 0, 0, 0, 0, 0);
        add_row(bfra_pkg::REQ_ADVANCE, 0, 0, 0, 24'hFFFFFF, 0, bfra_pkg::ST_OK,
                0, 0, 0, 0, 0);
        foreach (dir_rows[i])
            issue(dir_rows[i]);
        drain();

        // each size setting gets its own random phase; one phase runs without gaps
        for (int ph = 0; ph < 8; ph++)
        begin
            write_size(17'(sizes[ph]));
            quiet = (ph == 6);
            for (int n = 0; n < 200; n++)
                issue(random_item());
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
